FILE: sv/blr_pkg.sv
package blr_pkg;

    // Coordinate width of the framebuffer.
    localparam int COORD_BITS = 12;
    // Signed error term and doubled deltas of the Bresenham walk.
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int TWICE_BITS = COORD_BITS + 1;

    localparam int ADDR_BITS  = 32;
    localparam int PITCH_BITS = 16;
    localparam int COLOR_BITS = 8;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_BASE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_PITCH  = 1'd1;

    localparam logic [ADDR_BITS-1:0]  FRAME_BASE_RESET = 32'hE000_0000;
    localparam logic [PITCH_BITS-1:0] ROW_PITCH_RESET  = 16'd3072;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COLOR_BITS-1:0] t_color;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_STEP = 1'b1
    } t_func;

    // Endpoints and color of a load item.
    typedef struct packed {
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
        t_color red;
        t_color green;
        t_color blue;
    } t_line;

    // One pixel of a line, before its address is formed.
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_color red;
        t_color green;
        t_color blue;
        logic   last;
    } t_pixel;

endpackage

FILE: sv/blr_ifs.sv
interface blr_in_if
    import blr_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   func;
    t_coord x_start;
    t_coord y_start;
    t_coord x_end;
    t_coord y_end;
    t_color red;
    t_color green;
    t_color blue;

    modport source (
        output valid, func, x_start, y_start, x_end, y_end, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, func, x_start, y_start, x_end, y_end, red, green, blue,
        output ready
    );
endinterface

interface blr_out_if
    import blr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    t_coord               pixel_x;
    t_coord               pixel_y;
    logic [ADDR_BITS-1:0] byte_address;
    t_color               out_red;
    t_color               out_green;
    t_color               out_blue;
    logic                 last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, byte_address, out_red, out_green, out_blue,
               last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, byte_address, out_red, out_green, out_blue,
               last_pixel,
        output ready
    );
endinterface

interface blr_cfg_if
    import blr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: sv/blr_walker.sv
module blr_walker
    import blr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  t_func  i_func,
    input  t_line  i_line,
    output t_pixel o_pix,
    output logic   o_pix_valid,
    output logic   o_busy
);

    t_coord                r_cur_x, r_cur_y, r_stop_x, r_stop_y;
    logic [ERR_BITS-1:0]   r_err;
    logic [TWICE_BITS-1:0] r_twice_dx, r_twice_dy;
    logic                  r_y_down, r_steep, r_busy;
    t_color                r_red, r_green, r_blue;

    t_coord                n_cur_x, n_cur_y, n_stop_x, n_stop_y;
    logic [ERR_BITS-1:0]   n_err;
    logic [TWICE_BITS-1:0] n_twice_dx, n_twice_dy;
    logic                  n_y_down, n_steep, n_busy;
    t_color                n_red, n_green, n_blue;

    // Load setup: the walk always starts at the smaller column.
    logic   swap;
    t_coord ax, ay, bx, by, dx, dy;
    logic   ld_y_down, ld_steep;

    // Step: one move along the major axis, a conditional one along the minor.
    logic                last;
    logic                err_pos;
    t_coord              y_next;
    logic [ERR_BITS-1:0] err_major, err_minor;

    always_comb begin
        swap      = i_line.x_start > i_line.x_end;
        ax        = swap ? i_line.x_end   : i_line.x_start;
        ay        = swap ? i_line.y_end   : i_line.y_start;
        bx        = swap ? i_line.x_start : i_line.x_end;
        by        = swap ? i_line.y_start : i_line.y_end;
        dx        = bx - ax;
        ld_y_down = by < ay;
        dy        = ld_y_down ? (ay - by) : (by - ay);
        ld_steep  = dx < dy;
    end

    always_comb begin
        last    = r_steep ? (r_cur_y == r_stop_y) : (r_cur_x == r_stop_x);
        err_pos = !r_err[ERR_BITS-1] && (r_err != '0);
        y_next  = r_y_down ? (r_cur_y - t_coord'(1)) : (r_cur_y + t_coord'(1));
        if (r_steep) begin
            err_major = {2'b00, r_twice_dx};
            err_minor = {2'b00, r_twice_dy};
        end else begin
            err_major = {2'b00, r_twice_dy};
            err_minor = {2'b00, r_twice_dx};
        end
    end

    always_comb begin
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_stop_x   = r_stop_x;
        n_stop_y   = r_stop_y;
        n_err      = r_err;
        n_twice_dx = r_twice_dx;
        n_twice_dy = r_twice_dy;
        n_y_down   = r_y_down;
        n_steep    = r_steep;
        n_busy     = r_busy;
        n_red      = r_red;
        n_green    = r_green;
        n_blue     = r_blue;
        if (i_accept) begin
            case (i_func)
                FUNC_LOAD: begin
                    n_cur_x    = ax;
                    n_cur_y    = ay;
                    n_stop_x   = bx;
                    n_stop_y   = by;
                    n_twice_dx = {dx, 1'b0};
                    n_twice_dy = {dy, 1'b0};
                    n_y_down   = ld_y_down;
                    n_steep    = ld_steep;
                    n_err      = ld_steep ? ({2'b00, dx, 1'b0} - {3'b000, dy})
                                          : ({2'b00, dy, 1'b0} - {3'b000, dx});
                    n_red      = i_line.red;
                    n_green    = i_line.green;
                    n_blue     = i_line.blue;
                    n_busy     = 1'b1;
                end
                FUNC_STEP: begin
                    if (r_busy) begin
                        if (last) begin
                            n_busy = 1'b0;
                        end else begin
                            n_err = r_err + err_major - (err_pos ? err_minor : '0);
                            if (r_steep) begin
                                n_cur_y = y_next;
                                if (err_pos) begin
                                    n_cur_x = r_cur_x + t_coord'(1);
                                end
                            end else begin
                                n_cur_x = r_cur_x + t_coord'(1);
                                if (err_pos) begin
                                    n_cur_y = y_next;
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_busy = r_busy;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_stop_x   <= '0;
            r_stop_y   <= '0;
            r_err      <= '0;
            r_twice_dx <= '0;
            r_twice_dy <= '0;
            r_y_down   <= 1'b0;
            r_steep    <= 1'b0;
            r_busy     <= 1'b0;
            r_red      <= '0;
            r_green    <= '0;
            r_blue     <= '0;
        end else begin
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_stop_x   <= n_stop_x;
            r_stop_y   <= n_stop_y;
            r_err      <= n_err;
            r_twice_dx <= n_twice_dx;
            r_twice_dy <= n_twice_dy;
            r_y_down   <= n_y_down;
            r_steep    <= n_steep;
            r_busy     <= n_busy;
            r_red      <= n_red;
            r_green    <= n_green;
            r_blue     <= n_blue;
        end
    end

    always_comb begin
        o_pix.x     = r_cur_x;
        o_pix.y     = r_cur_y;
        o_pix.red   = r_red;
        o_pix.green = r_green;
        o_pix.blue  = r_blue;
        o_pix.last  = last;
        o_pix_valid = i_accept && (i_func == FUNC_STEP) && r_busy;
        o_busy      = r_busy;
    end

endmodule

FILE: sv/blr_addr_stage.sv
module blr_addr_stage
    import blr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_pixel                i_pix,
    input  logic                  i_pix_valid,
    input  logic [ADDR_BITS-1:0]  i_frame_base,
    input  logic [PITCH_BITS-1:0] i_row_pitch,
    input  logic                  i_out_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output t_pixel                o_pix,
    output logic [ADDR_BITS-1:0]  o_addr
);

    logic                 r_sv, r_ov;
    t_pixel               r_spix, r_opix;
    logic [ADDR_BITS-1:0] r_oaddr;

    logic                            adv;
    logic [COORD_BITS+PITCH_BITS-1:0] row_offs;
    logic [COORD_BITS+1:0]            col_offs;
    logic [ADDR_BITS-1:0]             n_addr;

    always_comb begin
        adv      = !r_ov || i_out_ready;
        o_ready  = !r_sv || adv;
        row_offs = r_spix.y * i_row_pitch;
        col_offs = {1'b0, r_spix.x, 1'b0} + {2'b00, r_spix.x};
        n_addr   = i_frame_base + ADDR_BITS'(row_offs) + ADDR_BITS'(col_offs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv) begin
                r_ov <= r_sv;
            end
            if (o_ready) begin
                r_sv <= i_pix_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_sv) begin
            r_opix  <= r_spix;
            r_oaddr <= n_addr;
        end
        if (o_ready && i_pix_valid) begin
            r_spix <= i_pix;
        end
    end

    assign o_valid = r_ov;
    assign o_pix   = r_opix;
    assign o_addr  = r_oaddr;

endmodule

FILE: sv/bresenham_line_rasterizer.sv
// Line rasterizer for a framebuffer with three bytes per pixel.
// Items arrive on i_item. A load item (func 0) sets up a line between two
// endpoints with a color and produces no pixel. Each step item (func 1)
// produces one pixel on o_pixel: its column, row, the address of its blue
// byte (frame base plus row times pitch plus three times column, wrapping at
// 32 bits) and the color bytes; the far endpoint carries last_pixel. A step
// item while no line is active produces nothing. A load during a line
// replaces it.
// Throughput is one item per cycle while i_item ready is high: the walker state
// updates at the edge that accepts an item. A pixel is captured at the edge
// that accepts its step item, in one register ahead of the address
// multiplier, and then moves to one output register after it, which drives
// o_pixel.
// When the receiver stalls, the two pixel registers fill and then i_item
// ready drops until o_pixel drains; no pixel is lost or repeated.
// i_cfg writes frame_base (index 0) or row_pitch (index 1) and is always
// ready; write it only while no pixel is in flight.
// Synchronous reset puts the walker idle, empties both pixel registers and
// restores frame_base to 0xE0000000 and row_pitch to 3072.
module bresenham_line_rasterizer
    import blr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    blr_in_if.sink    i_item,
    blr_out_if.source o_pixel,
    blr_cfg_if.sink   i_cfg
);

    // Configuration registers.
    logic [ADDR_BITS-1:0]  r_frame_base;
    logic [PITCH_BITS-1:0] r_row_pitch;

    // Handshake on the item channel.
    logic   item_accept;
    t_func  item_func;
    t_line  item_line;

    // Pixel from the walker into the address stage.
    t_pixel walk_pix;
    logic   walk_pix_valid;
    logic   walk_busy;

    // Address stage results.
    logic                 stage_ready;
    logic                 out_valid;
    t_pixel               out_pix;
    logic [ADDR_BITS-1:0] out_addr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= FRAME_BASE_RESET;
            r_row_pitch  <= ROW_PITCH_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FRAME_BASE: r_frame_base <= i_cfg.data;
                REG_ROW_PITCH:  r_row_pitch  <= i_cfg.data[PITCH_BITS-1:0];
                default:        r_frame_base <= r_frame_base;
            endcase
        end
    end

    // An item is taken whenever the address stage can take a pixel, so a
    // step item never has to wait for its own pixel to find room.
    assign i_item.ready = stage_ready;
    assign item_accept  = i_item.valid && stage_ready;
    assign item_func    = t_func'(i_item.func);

    always_comb begin
        item_line.x_start = i_item.x_start;
        item_line.y_start = i_item.y_start;
        item_line.x_end   = i_item.x_end;
        item_line.y_end   = i_item.y_end;
        item_line.red     = i_item.red;
        item_line.green   = i_item.green;
        item_line.blue    = i_item.blue;
    end

    blr_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (item_accept),
        .i_func      (item_func),
        .i_line      (item_line),
        .o_pix       (walk_pix),
        .o_pix_valid (walk_pix_valid),
        .o_busy      (walk_busy)
    );

    blr_addr_stage u_addr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (walk_pix),
        .i_pix_valid  (walk_pix_valid),
        .i_frame_base (r_frame_base),
        .i_row_pitch  (r_row_pitch),
        .i_out_ready  (o_pixel.ready),
        .o_ready      (stage_ready),
        .o_valid      (out_valid),
        .o_pix        (out_pix),
        .o_addr       (out_addr)
    );

    assign o_pixel.valid        = out_valid;
    assign o_pixel.pixel_x      = out_pix.x;
    assign o_pixel.pixel_y      = out_pix.y;
    assign o_pixel.byte_address = out_addr;
    assign o_pixel.out_red      = out_pix.red;
    assign o_pixel.out_green    = out_pix.green;
    assign o_pixel.out_blue     = out_pix.blue;
    assign o_pixel.last_pixel   = out_pix.last;

`ifndef NO_ASSERTIONS
    // A load always leaves an active line behind it.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_accept && (item_func == FUNC_LOAD) |=> walk_busy)
        else $error("walker idle after a load item");

    // The far endpoint ends the line.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_pix_valid && walk_pix.last |=> !walk_busy)
        else $error("walker still busy after the last pixel");

    // A step while idle produces no pixel.
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !walk_busy |-> !walk_pix_valid)
        else $error("pixel produced while no line is active");

    // The walker never hands a pixel to a stage that cannot take it.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_pix_valid |-> stage_ready)
        else $error("pixel offered while the address stage is full");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the line rasterizer. Items are offered from a
// queue of pending items. Every item that the block accepts also goes
// through a software copy of the line walker, which appends the pixel
// that the item should produce to a queue of expected pixel writes. Each
// pixel that the block hands out is compared field by field with the oldest
// entry of that queue. Register writes go through their own queue and are
// only issued while nothing is in flight.
module testbench;
    import blr_pkg::*;

    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int CYCLE_LIMIT   = 400000;
    // The pixel path is two registers deep, so this quiet time is plenty to be
    // sure that nothing is still on its way out.
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        t_func func;
        t_line line;
    } t_line_item;

    typedef struct {
        t_coord               x;
        t_coord               y;
        logic [ADDR_BITS-1:0] addr;
        t_color               red;
        t_color               green;
        t_color               blue;
        logic                 last;
    } t_pixel_write;

    typedef struct {
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_reg_write;

    logic i_clk;
    logic i_rst_n;

    blr_in_if  item_if ();
    blr_out_if pixel_if ();
    blr_cfg_if cfg_if ();

    bresenham_line_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_pixel (pixel_if),
        .i_cfg   (cfg_if)
    );

    t_line_item   pending_items[$];
    t_pixel_write expected_pixels[$];
    t_reg_write   pending_writes[$];

    // Shadow copy of the registers and of the line walker.
    logic [ADDR_BITS-1:0]       base_addr;
    logic [PITCH_BITS-1:0]      pitch;
    t_coord                     walk_x;
    t_coord                     walk_y;
    t_coord                     end_x;
    t_coord                     end_y;
    logic signed [ERR_BITS-1:0] walk_err;
    logic [TWICE_BITS-1:0]      dbl_dx;
    logic [TWICE_BITS-1:0]      dbl_dy;
    logic                       walk_down;
    logic                       walk_steep;
    logic                       line_active;
    t_color                     line_red;
    t_color                     line_green;
    t_color                     line_blue;

    bit idling_on   = 1'b0;
    bit hold_armed  = 1'b0;
    bit hold_done   = 1'b0;
    int send_gap    = 0;
    int recv_gap    = 0;
    int hold_left   = 0;
    int error_count = 0;
    int cycle_count = 0;
    int items_planned = 0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Advance the shadow walker by one accepted item. A load sets up the
    // walk and produces nothing; a step while a line is active produces one
    // pixel and moves to the next one.
    function automatic void rasterize_item(input t_line_item it);
        t_coord       ax;
        t_coord       ay;
        t_coord       bx;
        t_coord       by;
        t_coord       tmp;
        int           dx;
        int           dy;
        t_pixel_write px;

        if (it.func == FUNC_LOAD) begin
            ax = it.line.x_start;
            ay = it.line.y_start;
            bx = it.line.x_end;
            by = it.line.y_end;
            // The walk always runs toward the larger column.
            if (ax > bx) begin
                tmp = ax; ax = bx; bx = tmp;
                tmp = ay; ay = by; by = tmp;
            end
            dx = int'(bx) - int'(ax);
            walk_down = (by < ay);
            dy = walk_down ? int'(ay) - int'(by) : int'(by) - int'(ay);
            walk_x = ax;
            walk_y = ay;
            end_x = bx;
            end_y = by;
            dbl_dx = TWICE_BITS'(2 * dx);
            dbl_dy = TWICE_BITS'(2 * dy);
            walk_steep = (dx < dy);
            walk_err = ERR_BITS'(walk_steep ? 2 * dx - dy : 2 * dy - dx);
            line_red = it.line.red;
            line_green = it.line.green;
            line_blue = it.line.blue;
            line_active = 1'b1;
        end else if (line_active) begin
            px.x = walk_x;
            px.y = walk_y;
            // All terms are widened to 32 bits, so the sum wraps there.
            px.addr = base_addr + walk_y * pitch + 32'd3 * walk_x;
            px.red = line_red;
            px.green = line_green;
            px.blue = line_blue;
            px.last = walk_steep ? (walk_y == end_y) : (walk_x == end_x);
            expected_pixels.push_back(px);
            if (px.last) begin
                line_active = 1'b0;
            end else if (walk_steep) begin
                // The minor coordinate moves only on a strictly positive error.
                if (walk_err > 0) begin
                    walk_x = walk_x + 1'b1;
                    walk_err = walk_err - dbl_dy;
                end
                walk_err = walk_err + dbl_dx;
                walk_y = walk_down ? walk_y - 1'b1 : walk_y + 1'b1;
            end else begin
                if (walk_err > 0) begin
                    walk_y = walk_down ? walk_y - 1'b1 : walk_y + 1'b1;
                    walk_err = walk_err - dbl_dx;
                end
                walk_err = walk_err + dbl_dy;
                walk_x = walk_x + 1'b1;
            end
        end
    endfunction

    function automatic t_line random_line();
        t_line ln;
        ln.x_start = t_coord'($urandom());
        ln.y_start = t_coord'($urandom());
        ln.x_end   = t_coord'($urandom());
        ln.y_end   = t_coord'($urandom());
        ln.red     = t_color'($urandom());
        ln.green   = t_color'($urandom());
        ln.blue    = t_color'($urandom());
        return ln;
    endfunction

    function automatic void queue_item(input t_func func, input t_line ln);
        t_line_item it;
        it.func = func;
        it.line = ln;
        pending_items.push_back(it);
        items_planned++;
    endfunction

    // Step items ignore their payload, so it is left random.
    function automatic void queue_steps(input int count);
        repeat (count) queue_item(FUNC_STEP, random_line());
    endfunction

    function automatic void queue_load(input int xs, input int ys, input int xe, input int ye,
                                       input int r, input int g, input int b);
        t_line ln;
        ln.x_start = t_coord'(xs);
        ln.y_start = t_coord'(ys);
        ln.x_end   = t_coord'(xe);
        ln.y_end   = t_coord'(ye);
        ln.red     = t_color'(r);
        ln.green   = t_color'(g);
        ln.blue    = t_color'(b);
        queue_item(FUNC_LOAD, ln);
    endfunction

    // A load at a random place and in a random octant, followed mostly by
    // exactly the steps that the line needs. Now and then the line is cut
    // short by the next load, or trailed by steps that find the walker idle.
    function automatic void plan_random_line();
        int major;
        int minor;
        int dx;
        int dy;
        int x0;
        int y0;
        int x1;
        int y1;
        int steps;

        major = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 600) : $urandom_range(0, 24);
        minor = $urandom_range(0, major);
        if ($urandom_range(0, 1) == 1) begin
            dx = major;
            dy = minor;
        end else begin
            dx = minor;
            dy = major;
        end
        x0 = $urandom_range(0, COORD_MAX);
        y0 = $urandom_range(0, COORD_MAX);
        x1 = ($urandom_range(0, 1) == 1) ? x0 + dx : x0 - dx;
        if (x1 > COORD_MAX) x1 = x0 - dx;
        if (x1 < 0) x1 = x0 + dx;
        y1 = ($urandom_range(0, 1) == 1) ? y0 + dy : y0 - dy;
        if (y1 > COORD_MAX) y1 = y0 - dy;
        if (y1 < 0) y1 = y0 + dy;
        queue_load(x0, y0, x1, y1, $urandom(), $urandom(), $urandom());
        case ($urandom_range(0, 7))
            0: steps = $urandom_range(0, major);
            1: steps = major + 1 + $urandom_range(1, 4);
            default: steps = major + 1;
        endcase
        queue_steps(steps);
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_pixels.size() != 0 ||
               pending_writes.size() != 0 || item_if.valid || cfg_if.valid) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        t_reg_write wr;
        wr.index = index;
        wr.data = data;
        pending_writes.push_back(wr);
        wait_drained();
    endtask

    task automatic run_phase(input int count, input bit idle_en);
        int first;
        idling_on = idle_en;
        first = items_planned;
        while (items_planned - first < count) begin
            // About one in ten entries is a fully random item: a stray step
            // or a load of a long line that the next load throws away.
            if ($urandom_range(0, 9) == 0) begin
                queue_item(t_func'($urandom_range(0, 1)), random_line());
            end else begin
                plan_random_line();
            end
        end
        wait_drained();
    endtask

    // Item driver. An offered item stays on the bus until it is taken; gaps
    // are only opened between items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                rasterize_item(pending_items.pop_front());
            end
            if (!item_if.valid || item_if.ready) begin
                if (send_gap == 0 && idling_on && pending_items.size() != 0 &&
                    $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(1, 18);
                end
                if (send_gap != 0) begin
                    send_gap--;
                    item_if.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    item_if.valid   <= 1'b1;
                    item_if.func    <= pending_items[0].func;
                    item_if.x_start <= pending_items[0].line.x_start;
                    item_if.y_start <= pending_items[0].line.y_start;
                    item_if.x_end   <= pending_items[0].line.x_end;
                    item_if.y_end   <= pending_items[0].line.y_end;
                    item_if.red     <= pending_items[0].line.red;
                    item_if.green   <= pending_items[0].line.green;
                    item_if.blue    <= pending_items[0].line.blue;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Register writes. The shadow registers change at the same edge as the
    // real ones.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_if.valid <= 1'b0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (pending_writes[0].index)
                    REG_FRAME_BASE: base_addr = pending_writes[0].data;
                    REG_ROW_PITCH:  pitch = pending_writes[0].data[PITCH_BITS-1:0];
                    default: ;
                endcase
                void'(pending_writes.pop_front());
            end
            if (!cfg_if.valid || cfg_if.ready) begin
                if (pending_writes.size() != 0) begin
                    cfg_if.valid <= 1'b1;
                    cfg_if.index <= pending_writes[0].index;
                    cfg_if.data  <= pending_writes[0].data;
                end else begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor and receiver back-pressure. Once armed, the long hold
    // keeps ready low so that the block's output registers fill and its item
    // input stalls.
    always @(posedge i_clk) begin
        t_pixel_write want;
        if (!i_rst_n) begin
            pixel_if.ready <= 1'b0;
        end else begin
            if (pixel_if.valid && pixel_if.ready) begin
                if (expected_pixels.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("unexpected pixel: x=%0d y=%0d addr=%h rgb=%h%h%h last=%b",
                                 pixel_if.pixel_x, pixel_if.pixel_y, pixel_if.byte_address,
                                 pixel_if.out_red, pixel_if.out_green, pixel_if.out_blue,
                                 pixel_if.last_pixel);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (pixel_if.pixel_x !== want.x || pixel_if.pixel_y !== want.y ||
                        pixel_if.byte_address !== want.addr ||
                        pixel_if.out_red !== want.red || pixel_if.out_green !== want.green ||
                        pixel_if.out_blue !== want.blue || pixel_if.last_pixel !== want.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("pixel mismatch: expected x=%0d y=%0d addr=%h rgb=%h%h%h last=%b",
                                     want.x, want.y, want.addr, want.red, want.green, want.blue,
                                     want.last);
                            $display("                actual   x=%0d y=%0d addr=%h rgb=%h%h%h last=%b",
                                     pixel_if.pixel_x, pixel_if.pixel_y, pixel_if.byte_address,
                                     pixel_if.out_red, pixel_if.out_green, pixel_if.out_blue,
                                     pixel_if.last_pixel);
                        end
                    end
                end
            end
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                pixel_if.ready <= 1'b0;
            end else begin
                if (recv_gap == 0 && idling_on && $urandom_range(0, 11) == 0) begin
                    recv_gap = $urandom_range(1, 18);
                end
                if (recv_gap != 0) begin
                    recv_gap--;
                    pixel_if.ready <= 1'b0;
                end else begin
                    pixel_if.ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog for a block that hangs or stops producing pixels.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        item_if.valid   = 1'b0;
        item_if.func    = FUNC_LOAD;
        item_if.x_start = '0;
        item_if.y_start = '0;
        item_if.x_end   = '0;
        item_if.y_end   = '0;
        item_if.red     = '0;
        item_if.green   = '0;
        item_if.blue    = '0;
        pixel_if.ready  = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = REG_FRAME_BASE;
        cfg_if.data     = '0;

        base_addr   = FRAME_BASE_RESET;
        pitch       = ROW_PITCH_RESET;
        walk_x      = '0;
        walk_y      = '0;
        end_x       = '0;
        end_y       = '0;
        walk_err    = '0;
        dbl_dx      = '0;
        dbl_dy      = '0;
        walk_down   = 1'b0;
        walk_steep  = 1'b0;
        line_active = 1'b0;
        line_red    = '0;
        line_green  = '0;
        line_blue   = '0;

        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines with the reset register values.
        idling_on = 1'b1;
        // A step straight after reset finds no line.
        queue_steps(1);
        // A single point: one pixel with the last mark, then an idle step.
        queue_load(0, 0, 0, 0, 8'h00, 8'h00, 8'h00);
        queue_steps(2);
        // Endpoints given in reverse column order on a steep line, at the
        // far corner of the coordinate space.
        queue_load(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX - 4, 8'hFF, 8'hFF, 8'hFF);
        queue_steps(4);
        // A shallow line going up the rows, replaced by a new load halfway.
        queue_load(0, COORD_MAX, 3, COORD_MAX - 1, 8'h12, 8'h34, 8'h56);
        queue_steps(2);
        // The error term starts at zero here, so the first decision is a tie.
        queue_load(10, 10, 14, 12, 8'hA5, 8'h5A, 8'hC3);
        queue_steps(5);
        // Steep with decreasing rows, endpoints swapped.
        queue_load(7, 14, 5, 20, 8'h01, 8'h80, 8'h7F);
        queue_steps(7);
        wait_drained();

        // Both registers at zero; the long receiver hold happens here.
        write_reg(REG_FRAME_BASE, 32'h0000_0000);
        write_reg(REG_ROW_PITCH, 32'h0000_0000);
        hold_armed = 1'b1;
        run_phase(300, 1'b1);

        // Both registers at their maximum, so addresses wrap; no idling.
        write_reg(REG_FRAME_BASE, 32'hFFFF_FFFF);
        write_reg(REG_ROW_PITCH, 32'h0000_FFFF);
        run_phase(300, 1'b0);

        // Random values; the pitch write carries random upper bits too.
        write_reg(REG_FRAME_BASE, $urandom());
        write_reg(REG_ROW_PITCH, $urandom());
        run_phase(350, 1'b1);

        // Densely packed rows.
        write_reg(REG_FRAME_BASE, FRAME_BASE_RESET);
        write_reg(REG_ROW_PITCH, 32'd3);
        run_phase(300, 1'b1);

        // The closing stretch runs without idling on either side.
        write_reg(REG_FRAME_BASE, $urandom());
        write_reg(REG_ROW_PITCH, $urandom_range(0, 65535));
        run_phase(350, 1'b0);

        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
